>>> rtl/planar_arm_forward_kinematics_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the forward kinematics core.
// ----------------------------------------------------------------------------
`ifndef PLANAR_ARM_FORWARD_KINEMATICS_CORE_ASSERT_SVH
`define PLANAR_ARM_FORWARD_KINEMATICS_CORE_ASSERT_SVH

// same-cycle implication, disabled while reset is held
`define PAFK_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is held
`define PAFK_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/pafk_pkg.sv
// ----------------------------------------------------------------------------
// pafk_pkg
// Types, constants and angle reduction shared by the kinematics core.
// ----------------------------------------------------------------------------
package pafk_pkg;

    // joint angle inputs, 1/64 degree per unit
    localparam int ANGLE_IN_W = 16;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_HAND_OFFSET_X    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HAND_OFFSET_Y    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FOREARM_OFFSET_X = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FOREARM_OFFSET_Y = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ARM_OFFSET_X     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ARM_OFFSET_Y     = 3'd5;

    // angle reduction constants, 18 bit signed
    localparam logic signed [17:0] FULL_TURN    = 18'sd23040;
    localparam logic signed [17:0] HALF_TURN    = 18'sd11520;
    localparam logic signed [17:0] QUARTER_TURN = 18'sd5760;
    localparam logic signed [17:0] TWO_TURNS    = 18'sd46080;
    localparam logic signed [17:0] COARSE_LIMIT = 18'sd34560;

    // residue after quadrant folding lies in [-5760, 5760]
    localparam int RESIDUE_W = 14;

    // gain compensation: K = 636751 / 2^20, rounded half up by 2^11 then >> 12
    localparam int GAIN_W = 21;
    localparam logic signed [GAIN_W-1:0] GAIN_Q20 = 21'sd636751;
    localparam int GAIN_SHIFT = 12;
    localparam int GAIN_ROUND = 2048;

    // rotation datapath: guard fraction bits and headroom over the inner width
    localparam int FRAC_GUARD  = 8;
    localparam int GUARD_ROUND = 128;
    localparam int DATA_EXTRA  = 10;

    // residual angle in units of 2^-22 degree
    localparam int ANGLE_W = 31;
    localparam int ATAN_ENTRIES = 24;
    localparam logic signed [ANGLE_W-1:0] ATAN_FINE [ATAN_ENTRIES] = '{
        31'sd188743680, 31'sd111421900, 31'sd58872272, 31'sd29884485,
        31'sd15000234,  31'sd7507429,   31'sd3754631,  31'sd1877430,
        31'sd938729,    31'sd469366,    31'sd234683,   31'sd117342,
        31'sd58671,     31'sd29335,     31'sd14668,    31'sd7334,
        31'sd3667,      31'sd1833,      31'sd917,      31'sd458,
        31'sd229,       31'sd115,       31'sd57,       31'sd29
    };

    // reduced turn handed to a joint section
    typedef struct packed {
        logic                         fold;
        logic signed [RESIDUE_W-1:0]  res;
    } t_turn;

    // wrap an angle sum into [-180, 180) degrees, then fold into [-90, 90]
    function automatic t_turn reduce_angle(input logic signed [ANGLE_IN_W:0] a);
        logic signed [17:0] s0;
        logic signed [17:0] s1;
        logic signed [17:0] s2;
        t_turn t;
        s0 = 18'(a);
        if (s0 >= COARSE_LIMIT) begin
            s1 = s0 - TWO_TURNS;
        end else if (s0 < -COARSE_LIMIT) begin
            s1 = s0 + TWO_TURNS;
        end else begin
            s1 = s0;
        end
        if (s1 >= HALF_TURN) begin
            s2 = s1 - FULL_TURN;
        end else if (s1 < -HALF_TURN) begin
            s2 = s1 + FULL_TURN;
        end else begin
            s2 = s1;
        end
        if (s2 > QUARTER_TURN) begin
            t.fold = 1'b1;
            s2     = s2 - HALF_TURN;
        end else if (s2 < -QUARTER_TURN) begin
            t.fold = 1'b1;
            s2     = s2 + HALF_TURN;
        end else begin
            t.fold = 1'b0;
        end
        t.res = s2[RESIDUE_W-1:0];
        return t;
    endfunction

endpackage

>>> rtl/pafk_if.sv
// ----------------------------------------------------------------------------
// pafk interfaces
// Pose input, point output and register write channels of the core.
// ----------------------------------------------------------------------------

// pose item: starting point, head position and joint angles
interface pafk_in_if import pafk_pkg::*; #(
    parameter int COORD_BITS = 24
) ();
    logic                          valid;
    logic                          ready;
    logic signed [COORD_BITS-1:0]  start_x;
    logic signed [COORD_BITS-1:0]  start_y;
    logic signed [COORD_BITS-1:0]  head_x;
    logic signed [COORD_BITS-1:0]  head_y;
    logic signed [ANGLE_IN_W-1:0]  head_angle;
    logic signed [ANGLE_IN_W-1:0]  forearm_angle;
    logic signed [ANGLE_IN_W-1:0]  forearm_turn;
    logic signed [ANGLE_IN_W-1:0]  arm_angle;
    logic signed [ANGLE_IN_W-1:0]  arm_turn;

    modport source (
        output valid, start_x, start_y, head_x, head_y,
               head_angle, forearm_angle, forearm_turn, arm_angle, arm_turn,
        input  ready
    );
    modport sink (
        input  valid, start_x, start_y, head_x, head_y,
               head_angle, forearm_angle, forearm_turn, arm_angle, arm_turn,
        output ready
    );
endinterface

// result item: hand position in the world
interface pafk_out_if #(
    parameter int COORD_BITS = 24
) ();
    logic                          valid;
    logic                          ready;
    logic signed [COORD_BITS-1:0]  hand_x;
    logic signed [COORD_BITS-1:0]  hand_y;

    modport source (output valid, hand_x, hand_y, input ready);
    modport sink   (input valid, hand_x, hand_y, output ready);
endinterface

// register write channel
interface pafk_cfg_if import pafk_pkg::*; #(
    parameter int COORD_BITS = 24
) ();
    logic                    valid;
    logic                    ready;
    logic [CFG_IDX_W-1:0]    index;
    logic [COORD_BITS-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/pafk_cell.sv
// ----------------------------------------------------------------------------
// pafk_cell
// One CORDIC micro-rotation stage with its registers and item valid bit.
// ----------------------------------------------------------------------------
module pafk_cell import pafk_pkg::*; #(
    parameter int DATA_W = 37,
    parameter int SB_W   = 1,
    parameter int STAGE  = 0
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_vld,
    input  logic signed [DATA_W-1:0]  i_x,
    input  logic signed [DATA_W-1:0]  i_y,
    input  logic signed [ANGLE_W-1:0] i_z,
    input  logic [SB_W-1:0]           i_sb,
    output logic                      o_vld,
    output logic signed [DATA_W-1:0]  o_x,
    output logic signed [DATA_W-1:0]  o_y,
    output logic signed [ANGLE_W-1:0] o_z,
    output logic [SB_W-1:0]           o_sb
);

    localparam logic signed [ANGLE_W-1:0] STEP_ANGLE = ATAN_FINE[STAGE];

    logic signed [DATA_W-1:0]  w_xs;
    logic signed [DATA_W-1:0]  w_ys;
    logic signed [DATA_W-1:0]  n_x;
    logic signed [DATA_W-1:0]  n_y;
    logic signed [ANGLE_W-1:0] n_z;
    logic                      r_vld;
    logic signed [DATA_W-1:0]  r_x;
    logic signed [DATA_W-1:0]  r_y;
    logic signed [ANGLE_W-1:0] r_z;
    logic [SB_W-1:0]           r_sb;

    // floor shifts of both coordinates
    assign w_xs = i_x >>> STAGE;
    assign w_ys = i_y >>> STAGE;

    // turn towards zero residual angle
    always_comb begin
        if (!i_z[ANGLE_W-1]) begin
            n_x = i_x - w_ys;
            n_y = i_y + w_xs;
            n_z = i_z - STEP_ANGLE;
        end else begin
            n_x = i_x + w_ys;
            n_y = i_y - w_xs;
            n_z = i_z + STEP_ANGLE;
        end
    end

    // item valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    // stage payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x  <= n_x;
            r_y  <= n_y;
            r_z  <= n_z;
            r_sb <= i_sb;
        end
    end

    assign o_vld = r_vld;
    assign o_x   = r_x;
    assign o_y   = r_y;
    assign o_z   = r_z;
    assign o_sb  = r_sb;

endmodule

>>> rtl/pafk_joint.sv
// ----------------------------------------------------------------------------
// pafk_joint
// Move then turn of one link: offset add, gain scaling, quadrant fold,
// a chain of micro-rotation cells and guard-bit rounding.
// ----------------------------------------------------------------------------
module pafk_joint import pafk_pkg::*; #(
    parameter int COORD_BITS        = 24,
    parameter int ROTATE_ITERATIONS = 16,
    parameter int SB_W              = 1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_vld,
    input  logic signed [COORD_BITS+2:0]  i_x,
    input  logic signed [COORD_BITS+2:0]  i_y,
    input  logic signed [COORD_BITS-1:0]  i_dx,
    input  logic signed [COORD_BITS-1:0]  i_dy,
    input  t_turn                         i_turn,
    input  logic [SB_W-1:0]               i_sb,
    output logic                          o_vld,
    output logic signed [COORD_BITS+2:0]  o_x,
    output logic signed [COORD_BITS+2:0]  o_y,
    output logic [SB_W-1:0]               o_sb
);

    localparam int INNER_W = COORD_BITS + 3;
    localparam int PROD_W  = INNER_W + GAIN_W;
    localparam int DATA_W  = INNER_W + DATA_EXTRA;
    localparam int ROUND_W = DATA_W - FRAC_GUARD;
    localparam int N       = ROTATE_ITERATIONS;

    // clamp a one-bit-wider sum to the inner width
    function automatic logic signed [INNER_W-1:0] sat_sum(input logic signed [INNER_W:0] v);
        if (v[INNER_W] != v[INNER_W-1]) begin
            sat_sum = {v[INNER_W], {(INNER_W-1){~v[INNER_W]}}};
        end else begin
            sat_sum = v[INNER_W-1:0];
        end
    endfunction

    // clamp a rounded rotation result to the inner width
    function automatic logic signed [INNER_W-1:0] sat_round(input logic signed [ROUND_W-1:0] v);
        logic [ROUND_W-INNER_W:0] hi_bits;
        hi_bits = v[ROUND_W-1:INNER_W-1];
        if ((&hi_bits) || !(|hi_bits)) begin
            sat_round = v[INNER_W-1:0];
        end else begin
            sat_round = {v[ROUND_W-1], {(INNER_W-1){~v[ROUND_W-1]}}};
        end
    endfunction

    logic signed [INNER_W-1:0] n_mx;
    logic signed [INNER_W-1:0] n_my;
    logic signed [PROD_W-1:0]  w_px;
    logic signed [PROD_W-1:0]  w_py;
    logic signed [PROD_W-1:0]  w_prx;
    logic signed [PROD_W-1:0]  w_pry;
    logic signed [ANGLE_W-1:0] n_z;
    logic signed [DATA_W-1:0]  w_rx;
    logic signed [DATA_W-1:0]  w_ry;

    logic                      r0_vld;
    logic signed [INNER_W-1:0] r0_x;
    logic signed [INNER_W-1:0] r0_y;
    t_turn                     r0_turn;
    logic [SB_W-1:0]           r0_sb;

    logic                      r1_vld;
    logic signed [DATA_W-1:0]  r1_x;
    logic signed [DATA_W-1:0]  r1_y;
    t_turn                     r1_turn;
    logic [SB_W-1:0]           r1_sb;

    logic                      r2_vld;
    logic signed [DATA_W-1:0]  r2_x;
    logic signed [DATA_W-1:0]  r2_y;
    logic signed [ANGLE_W-1:0] r2_z;
    logic [SB_W-1:0]           r2_sb;

    logic                      r3_vld;
    logic signed [INNER_W-1:0] r3_x;
    logic signed [INNER_W-1:0] r3_y;
    logic [SB_W-1:0]           r3_sb;

    logic [N:0]                w_cvld;
    logic signed [DATA_W-1:0]  w_cx  [N+1];
    logic signed [DATA_W-1:0]  w_cy  [N+1];
    logic signed [ANGLE_W-1:0] w_cz  [N];
    logic [SB_W-1:0]           w_csb [N+1];

    // link offset add
    assign n_mx = sat_sum((INNER_W+1)'(i_x) + (INNER_W+1)'(i_dx));
    assign n_my = sat_sum((INNER_W+1)'(i_y) + (INNER_W+1)'(i_dy));

    // gain compensation product, rounded half up
    assign w_px  = r0_x * GAIN_Q20;
    assign w_py  = r0_y * GAIN_Q20;
    assign w_prx = w_px + PROD_W'(GAIN_ROUND);
    assign w_pry = w_py + PROD_W'(GAIN_ROUND);

    // residual angle scaled to 2^-22 degree
    assign n_z = ANGLE_W'(signed'({r1_turn.res, 16'h0000}));

    // valid bits of the front and back stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_vld <= 1'b0;
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
        end else if (i_en) begin
            r0_vld <= i_vld;
            r1_vld <= r0_vld;
            r2_vld <= r1_vld;
            r3_vld <= w_cvld[N];
        end
    end

    // move, scale and fold stages
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r0_x    <= n_mx;
            r0_y    <= n_my;
            r0_turn <= i_turn;
            r0_sb   <= i_sb;

            r1_x    <= DATA_W'(signed'(w_prx[PROD_W-1:GAIN_SHIFT]));
            r1_y    <= DATA_W'(signed'(w_pry[PROD_W-1:GAIN_SHIFT]));
            r1_turn <= r0_turn;
            r1_sb   <= r0_sb;

            r2_x    <= r1_turn.fold ? -r1_x : r1_x;
            r2_y    <= r1_turn.fold ? -r1_y : r1_y;
            r2_z    <= n_z;
            r2_sb   <= r1_sb;
        end
    end

    // micro-rotation chain
    assign w_cvld[0] = r2_vld;
    assign w_cx[0]   = r2_x;
    assign w_cy[0]   = r2_y;
    assign w_cz[0]   = r2_z;
    assign w_csb[0]  = r2_sb;

    for (genvar g = 0; g < N; g++) begin : g_cell
        if (g < N - 1) begin : g_mid
            pafk_cell #(
                .DATA_W (DATA_W),
                .SB_W   (SB_W),
                .STAGE  (g)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_en    (i_en),
                .i_vld   (w_cvld[g]),
                .i_x     (w_cx[g]),
                .i_y     (w_cy[g]),
                .i_z     (w_cz[g]),
                .i_sb    (w_csb[g]),
                .o_vld   (w_cvld[g+1]),
                .o_x     (w_cx[g+1]),
                .o_y     (w_cy[g+1]),
                .o_z     (w_cz[g+1]),
                .o_sb    (w_csb[g+1])
            );
        end else begin : g_last
            pafk_cell #(
                .DATA_W (DATA_W),
                .SB_W   (SB_W),
                .STAGE  (g)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_en    (i_en),
                .i_vld   (w_cvld[g]),
                .i_x     (w_cx[g]),
                .i_y     (w_cy[g]),
                .i_z     (w_cz[g]),
                .i_sb    (w_csb[g]),
                .o_vld   (w_cvld[g+1]),
                .o_x     (w_cx[g+1]),
                .o_y     (w_cy[g+1]),
                .o_z     (),
                .o_sb    (w_csb[g+1])
            );
        end
    end

    // drop guard bits, round half up
    assign w_rx = w_cx[N] + DATA_W'(GUARD_ROUND);
    assign w_ry = w_cy[N] + DATA_W'(GUARD_ROUND);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_x  <= sat_round(w_rx[DATA_W-1:FRAC_GUARD]);
            r3_y  <= sat_round(w_ry[DATA_W-1:FRAC_GUARD]);
            r3_sb <= w_csb[N];
        end
    end

    assign o_vld = r3_vld;
    assign o_x   = r3_x;
    assign o_y   = r3_y;
    assign o_sb  = r3_sb;

endmodule

>>> rtl/planar_arm_forward_kinematics_core.sv
// ----------------------------------------------------------------------------
// planar_arm_forward_kinematics_core
// Carries a point through hand, forearm and arm links and the head pose.
// ----------------------------------------------------------------------------
// Usage:
//   i_in takes one pose item (start point, head position, five angles) per
//   cycle while i_in.ready is high; o_out gives the hand position in world
//   coordinates, saturated. i_cfg writes the six link offsets by index; it
//   is always ready and must only be used while no item is in flight.
//   Writes to unused indexes drop.
// Throughput: one item per cycle while the pipeline is not held; each joint
//   is a move stage, a gain multiply stage, a fold stage, one cell per
//   micro-rotation and a round stage, all advancing together.
// Reset: clears all valid bits and the link offsets to zero.
// Stall: while o_out holds an item that is not taken, the pipeline keeps
//   moving as long as the stage behind the output register is empty; once
//   an item reaches it, every stage holds and i_in.ready drops.
// ----------------------------------------------------------------------------
`include "planar_arm_forward_kinematics_core_assert.svh"

module planar_arm_forward_kinematics_core import pafk_pkg::*; #(
    parameter int COORD_BITS        = 24,
    parameter int ROTATE_ITERATIONS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    pafk_in_if.sink       i_in,
    pafk_out_if.source    o_out,
    pafk_cfg_if.sink      i_cfg
);

    localparam int INNER_W = COORD_BITS + 3;
    localparam int TURN_W  = $bits(t_turn);
    localparam int HEAD_W  = 2 * COORD_BITS;
    localparam int SB0_W   = HEAD_W + 2 * TURN_W;
    localparam int SB1_W   = HEAD_W + TURN_W;
    localparam int SB2_W   = HEAD_W;

    // clamp the final sum to the output width
    function automatic logic signed [COORD_BITS-1:0] sat_out(input logic signed [INNER_W:0] v);
        logic [INNER_W-COORD_BITS+1:0] hi_bits;
        hi_bits = v[INNER_W:COORD_BITS-1];
        if ((&hi_bits) || !(|hi_bits)) begin
            sat_out = v[COORD_BITS-1:0];
        end else begin
            sat_out = {v[INNER_W], {(COORD_BITS-1){~v[INNER_W]}}};
        end
    endfunction

    logic signed [COORD_BITS-1:0] r_hand_off_x;
    logic signed [COORD_BITS-1:0] r_hand_off_y;
    logic signed [COORD_BITS-1:0] r_fore_off_x;
    logic signed [COORD_BITS-1:0] r_fore_off_y;
    logic signed [COORD_BITS-1:0] r_arm_off_x;
    logic signed [COORD_BITS-1:0] r_arm_off_y;

    logic                         w_en;
    logic                         w_load;
    t_turn                        w_turn_fore;
    t_turn                        w_turn_arm;
    t_turn                        w_turn_head;
    t_turn                        w_j1_turn;
    t_turn                        w_j2_turn;
    logic [SB0_W-1:0]             w_sb0_in;
    logic [SB0_W-1:0]             w_sb0_out;
    logic [SB1_W-1:0]             w_sb1_in;
    logic [SB1_W-1:0]             w_sb1_out;
    logic [SB2_W-1:0]             w_sb2_out;
    logic                         w_j0_vld;
    logic                         w_j1_vld;
    logic                         w_j2_vld;
    logic signed [INNER_W-1:0]    w_j0_x;
    logic signed [INNER_W-1:0]    w_j0_y;
    logic signed [INNER_W-1:0]    w_j1_x;
    logic signed [INNER_W-1:0]    w_j1_y;
    logic signed [INNER_W-1:0]    w_j2_x;
    logic signed [INNER_W-1:0]    w_j2_y;
    logic signed [COORD_BITS-1:0] w_head_x;
    logic signed [COORD_BITS-1:0] w_head_y;
    logic signed [INNER_W:0]      w_fx;
    logic signed [INNER_W:0]      w_fy;

    logic                         r_out_vld;
    logic signed [COORD_BITS-1:0] r_hand_x;
    logic signed [COORD_BITS-1:0] r_hand_y;

    // link offset registers
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hand_off_x <= '0;
            r_hand_off_y <= '0;
            r_fore_off_x <= '0;
            r_fore_off_y <= '0;
            r_arm_off_x  <= '0;
            r_arm_off_y  <= '0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_HAND_OFFSET_X:    r_hand_off_x <= i_cfg.data;
                CFG_HAND_OFFSET_Y:    r_hand_off_y <= i_cfg.data;
                CFG_FOREARM_OFFSET_X: r_fore_off_x <= i_cfg.data;
                CFG_FOREARM_OFFSET_Y: r_fore_off_y <= i_cfg.data;
                CFG_ARM_OFFSET_X:     r_arm_off_x  <= i_cfg.data;
                CFG_ARM_OFFSET_Y:     r_arm_off_y  <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    // pipeline advance: hold only when a finished item is blocked at the output
    assign w_load     = !r_out_vld || o_out.ready;
    assign w_en       = w_load || !w_j2_vld;
    assign i_in.ready = w_en;

    // angle sums wrapped and folded at entry
    assign w_turn_fore = reduce_angle((ANGLE_IN_W+1)'(i_in.forearm_angle)
                                      + (ANGLE_IN_W+1)'(i_in.forearm_turn));
    assign w_turn_arm  = reduce_angle((ANGLE_IN_W+1)'(i_in.arm_angle)
                                      + (ANGLE_IN_W+1)'(i_in.arm_turn));
    assign w_turn_head = reduce_angle((ANGLE_IN_W+1)'(i_in.head_angle));

    // items that ride along with the point
    assign w_sb0_in  = {i_in.head_x, i_in.head_y, w_turn_arm, w_turn_head};
    assign w_j1_turn = w_sb0_out[2*TURN_W-1:TURN_W];
    assign w_sb1_in  = {w_sb0_out[SB0_W-1:2*TURN_W], w_sb0_out[TURN_W-1:0]};
    assign w_j2_turn = w_sb1_out[TURN_W-1:0];
    assign w_head_x  = w_sb2_out[HEAD_W-1:COORD_BITS];
    assign w_head_y  = w_sb2_out[COORD_BITS-1:0];

    // hand link
    pafk_joint #(
        .COORD_BITS        (COORD_BITS),
        .ROTATE_ITERATIONS (ROTATE_ITERATIONS),
        .SB_W              (SB0_W)
    ) u_joint_fore (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (i_in.valid),
        .i_x     (INNER_W'(i_in.start_x)),
        .i_y     (INNER_W'(i_in.start_y)),
        .i_dx    (r_hand_off_x),
        .i_dy    (r_hand_off_y),
        .i_turn  (w_turn_fore),
        .i_sb    (w_sb0_in),
        .o_vld   (w_j0_vld),
        .o_x     (w_j0_x),
        .o_y     (w_j0_y),
        .o_sb    (w_sb0_out)
    );

    // forearm link
    pafk_joint #(
        .COORD_BITS        (COORD_BITS),
        .ROTATE_ITERATIONS (ROTATE_ITERATIONS),
        .SB_W              (SB1_W)
    ) u_joint_arm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_j0_vld),
        .i_x     (w_j0_x),
        .i_y     (w_j0_y),
        .i_dx    (r_fore_off_x),
        .i_dy    (r_fore_off_y),
        .i_turn  (w_j1_turn),
        .i_sb    (w_sb1_in),
        .o_vld   (w_j1_vld),
        .o_x     (w_j1_x),
        .o_y     (w_j1_y),
        .o_sb    (w_sb1_out)
    );

    // arm link and head turn
    pafk_joint #(
        .COORD_BITS        (COORD_BITS),
        .ROTATE_ITERATIONS (ROTATE_ITERATIONS),
        .SB_W              (SB2_W)
    ) u_joint_head (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_j1_vld),
        .i_x     (w_j1_x),
        .i_y     (w_j1_y),
        .i_dx    (r_arm_off_x),
        .i_dy    (r_arm_off_y),
        .i_turn  (w_j2_turn),
        .i_sb    (w_sb1_out[SB1_W-1:TURN_W]),
        .o_vld   (w_j2_vld),
        .o_x     (w_j2_x),
        .o_y     (w_j2_y),
        .o_sb    (w_sb2_out)
    );

    // head position add
    assign w_fx = (INNER_W+1)'(w_j2_x) + (INNER_W+1)'(w_head_x);
    assign w_fy = (INNER_W+1)'(w_j2_y) + (INNER_W+1)'(w_head_y);

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_load) begin
            r_out_vld <= w_j2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load && w_j2_vld) begin
            r_hand_x <= sat_out(w_fx);
            r_hand_y <= sat_out(w_fy);
        end
    end

    assign o_out.valid  = r_out_vld;
    assign o_out.hand_x = r_hand_x;
    assign o_out.hand_y = r_hand_y;

    // input back-pressure only comes from a blocked result
    `PAFK_ASSERT_IMPL(a_stall_cause, i_clk, i_rst_n, !i_in.ready, o_out.valid && !o_out.ready, "input stalled without a blocked result")
    // a held pipeline always has an item waiting behind the output
    `PAFK_ASSERT_IMPL(a_hold_full, i_clk, i_rst_n, !w_en, w_j2_vld && r_out_vld, "pipeline held with an empty last stage")
    // an item leaving the last joint lands in the output register
    `PAFK_ASSERT_NEXT(a_out_load, i_clk, i_rst_n, w_en && w_j2_vld, o_out.valid, "finished item lost before the output")

endmodule
